[design/stream_sequence_timing_monitor_top_defines.svh]
// Assertion macros for the stream sequence timing monitor.
// Included by the RTL files that carry concurrent assertions.
`ifndef STREAM_SEQUENCE_TIMING_MONITOR_TOP_DEFINES_SVH
`define STREAM_SEQUENCE_TIMING_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SSTM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define SSTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sstm_pkg.sv]
// Shared types and constants of the stream sequence timing monitor.
// No dependencies.
package sstm_pkg;

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned IN_TUSER_W  = 4;
  localparam int unsigned OUT_TDATA_W = 248;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHECK_SEQUENCE  = 2'd0,
    REG_CHECK_MONOTONIC = 2'd1,
    REG_GAP_CHECK_EN    = 2'd2,
    REG_GAP_THRESHOLD   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        check_sequence;
    logic        check_monotonic;
    logic        gap_check_enable;
    logic [63:0] gap_threshold_ns;
  } cfg_t;

  // tdata of an input transfer; strm_id sits in the lowest bits
  typedef struct packed {
    logic [15:0] payload_length;
    logic [63:0] ts_ns;
    logic [31:0] sequence_req;
    logic [7:0]  strm_id;
  } in_fields_t;

  // one stream table entry
  typedef struct packed {
    logic        valid;
    logic [31:0] prev_sequence;
    logic [63:0] last_timestamp;
    logic [31:0] records;
    logic [47:0] bytes;
    logic        contiguous;
    logic        monotonic;
  } entry_t;

  // result item; rec_ordinal sits in the lowest bits
  typedef struct packed {
    logic [31:0] kind_count;
    logic        stream_monotonic;
    logic        stream_contiguous;
    logic [47:0] stream_payload_total;
    logic [31:0] stream_record_count;
    logic [63:0] gap_delta_ns;
    logic        timeline_gap;
    logic        time_backward;
    logic [31:0] exp_sequence;
    logic        sequence_gap;
    logic        new_stream;
    logic [31:0] rec_ordinal;
  } report_t;

endpackage

[design/sstm_stream_table.sv]
// Per-stream state memory: one read port with registered data, one write port.
// Writes come either from the post-reset clearing sweep or from the update.
// Depends on sstm_pkg.
module sstm_stream_table import sstm_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o,
  input  logic          clr_en_i,
  input  logic [AW-1:0] clr_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i
);

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (clr_en_i) begin
      mem_q[clr_addr_i] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    // data holds between reads while the update stalls
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/sstm_kind_table.sv]
// Per-kind record counters in a memory, saturating increment on write-back.
// Depends on sstm_pkg.
module sstm_kind_table import sstm_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          clr_en_i,
  input  logic [AW-1:0] clr_addr_i,
  input  logic          upd_en_i,
  input  logic [AW-1:0] upd_addr_i,
  output logic [31:0]   count_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rd_data_q;

  assign count_o = (rd_data_q == '1) ? rd_data_q : rd_data_q + 32'd1;

  always_ff @(posedge clk_i) begin
    if (clr_en_i) begin
      mem_q[clr_addr_i] <= '0;
    end else if (upd_en_i) begin
      mem_q[upd_addr_i] <= count_o;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

endmodule

[design/sstm_check.sv]
// Record checks against the stream's previous entry; builds the new entry
// and the report. Purely combinational. Depends on sstm_pkg.
module sstm_check import sstm_pkg::*; (
  input  cfg_t        cfg_i,
  input  in_fields_t  rec_i,
  input  entry_t      entry_i,
  input  logic [31:0] ordinal_i,
  input  logic [31:0] kind_count_i,
  output entry_t      entry_o,
  output report_t     report_o
);

  logic        fresh;
  logic [31:0] expected;
  logic [64:0] diff;
  logic        below;
  logic        seq_gap;
  logic        backward;
  logic        tgap;
  logic [31:0] records;
  logic [47:0] bytes_base;
  logic [48:0] bytes_sum;
  logic [47:0] bytes;
  logic        contiguous;
  logic        monotonic;

  always_comb begin
    fresh    = !entry_i.valid;
    expected = entry_i.prev_sequence + 32'd1;
    // borrow out of the 65-bit difference flags a backward step
    diff     = {1'b0, rec_i.ts_ns} - {1'b0, entry_i.last_timestamp};
    below    = diff[64];

    seq_gap  = !fresh && cfg_i.check_sequence && (rec_i.sequence_req != expected);
    backward = !fresh && below && cfg_i.check_monotonic;
    tgap     = !fresh && !below && cfg_i.gap_check_enable &&
               (diff[63:0] > cfg_i.gap_threshold_ns);

    if (fresh) begin
      records = 32'd1;
    end else if (entry_i.records == '1) begin
      records = entry_i.records;
    end else begin
      records = entry_i.records + 32'd1;
    end

    bytes_base = fresh ? 48'd0 : entry_i.bytes;
    bytes_sum  = {1'b0, bytes_base} + 49'(rec_i.payload_length);
    bytes      = bytes_sum[48] ? '1 : bytes_sum[47:0];

    contiguous = fresh ? 1'b1 : (entry_i.contiguous && !seq_gap);
    monotonic  = fresh ? 1'b1 : (entry_i.monotonic && !backward);

    entry_o.valid          = 1'b1;
    entry_o.prev_sequence  = rec_i.sequence_req;
    entry_o.last_timestamp = rec_i.ts_ns;
    entry_o.records        = records;
    entry_o.bytes          = bytes;
    entry_o.contiguous     = contiguous;
    entry_o.monotonic      = monotonic;

    report_o.rec_ordinal          = ordinal_i;
    report_o.new_stream           = fresh;
    report_o.sequence_gap         = seq_gap;
    report_o.exp_sequence         = fresh ? 32'd0 : expected;
    report_o.time_backward        = backward;
    report_o.timeline_gap         = tgap;
    report_o.gap_delta_ns         = (fresh || below) ? 64'd0 : diff[63:0];
    report_o.stream_record_count  = records;
    report_o.stream_payload_total = bytes;
    report_o.stream_contiguous    = contiguous;
    report_o.stream_monotonic     = monotonic;
    report_o.kind_count           = kind_count_i;
  end

endmodule

[design/stream_sequence_timing_monitor_top.sv]
// Stream sequence timing monitor. One report per record: the record's stream
// entry and kind counter are read into registers in the accept cycle; once the
// output register has room, the record is checked and both are written back,
// and the next record is taken only after that write-back so that its table
// read sees it; this read-modify-write interlock keeps one record in flight. The
// report waits in an output register; while it is not taken, the next record
// holds after its table read and the input stays stalled. After reset a
// clearing pass zeroes both tables; records are taken only after it,
// configuration writes at any time.
// Depends on sstm_pkg, sstm_stream_table, sstm_kind_table, sstm_check.
`include "stream_sequence_timing_monitor_top_defines.svh"

module stream_sequence_timing_monitor_top import sstm_pkg::*; #(
  parameter int unsigned STREAMS = 256,
  parameter int unsigned KINDS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // strm_id[7:0], sequence_req[39:8], ts_ns[103:40], payload_length[119:104]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // record_kind[3:0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // rec_ordinal[31:0], new_stream[32], sequence_gap[33], exp_sequence[65:34],
  // time_backward[66], timeline_gap[67], gap_delta_ns[131:68],
  // stream_record_count[163:132], stream_payload_total[211:164],
  // stream_contiguous[212], stream_monotonic[213], kind_count[245:214], zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned SidW     = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int unsigned KidW     = (KINDS > 1) ? $clog2(KINDS) : 1;
  localparam int unsigned MaxDepth = (STREAMS > KINDS) ? STREAMS : KINDS;
  localparam int unsigned ClrW     = $clog2(MaxDepth);

  // stream and kind indexes folded onto the table depths
  logic [SidW-1:0] sid_lut [256];
  logic [KidW-1:0] kid_lut [16];

  for (genvar g = 0; g < 256; g++) begin : g_sid_lut
    assign sid_lut[g] = SidW'(g % STREAMS);
  end
  for (genvar g = 0; g < 16; g++) begin : g_kid_lut
    assign kid_lut[g] = KidW'(g % KINDS);
  end

  cfg_t            cfg_q;
  logic            clr_q;
  logic [ClrW-1:0] clr_cnt_q;
  logic            busy_q;
  logic            out_valid_q;
  report_t         out_q;
  logic [31:0]     ordinal_q;
  in_fields_t      rec_q;
  logic [SidW-1:0] sid_q;
  logic [KidW-1:0] kid_q;

  in_fields_t      rec_in;
  logic [SidW-1:0] sid_in;
  logic [KidW-1:0] kid_in;
  logic            accept;
  logic            fire;
  logic            clr_stream;
  logic            clr_kind;
  entry_t          entry_rd;
  entry_t          entry_wr;
  logic [31:0]     kind_count;
  report_t         report;

  assign rec_in = in_fields_t'(s_axis_tdata);
  assign sid_in = sid_lut[rec_in.strm_id];
  assign kid_in = kid_lut[s_axis_tuser];

  assign s_axis_tready = !clr_q && !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // check and write back once the output register has room
  assign fire          = busy_q && (!out_valid_q || m_axis_tready);

  assign clr_stream = clr_q && ({1'b0, clr_cnt_q} < (ClrW + 1)'(STREAMS));
  assign clr_kind   = clr_q && ({1'b0, clr_cnt_q} < (ClrW + 1)'(KINDS));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

  sstm_stream_table #(
    .DEPTH (STREAMS),
    .AW    (SidW)
  ) u_stream_table (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr_i  (sid_in),
    .rd_data_o  (entry_rd),
    .clr_en_i   (clr_stream),
    .clr_addr_i (clr_cnt_q[SidW-1:0]),
    .wr_en_i    (fire),
    .wr_addr_i  (sid_q),
    .wr_data_i  (entry_wr)
  );

  sstm_kind_table #(
    .DEPTH (KINDS),
    .AW    (KidW)
  ) u_kind_table (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr_i  (kid_in),
    .clr_en_i   (clr_kind),
    .clr_addr_i (clr_cnt_q[KidW-1:0]),
    .upd_en_i   (fire),
    .upd_addr_i (kid_q),
    .count_o    (kind_count)
  );

  sstm_check u_check (
    .cfg_i        (cfg_q),
    .rec_i        (rec_q),
    .entry_i      (entry_rd),
    .ordinal_i    (ordinal_q),
    .kind_count_i (kind_count),
    .entry_o      (entry_wr),
    .report_o     (report)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_sequence   <= 1'b1;
      cfg_q.check_monotonic  <= 1'b1;
      cfg_q.gap_check_enable <= 1'b0;
      cfg_q.gap_threshold_ns <= '0;
      clr_q                  <= 1'b1;
      clr_cnt_q              <= '0;
      busy_q                 <= 1'b0;
      out_valid_q            <= 1'b0;
      ordinal_q              <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_CHECK_SEQUENCE:  cfg_q.check_sequence   <= cfg_data_i[0];
          REG_CHECK_MONOTONIC: cfg_q.check_monotonic  <= cfg_data_i[0];
          REG_GAP_CHECK_EN:    cfg_q.gap_check_enable <= cfg_data_i[0];
          REG_GAP_THRESHOLD:   cfg_q.gap_threshold_ns <= cfg_data_i;
          default: ;
        endcase
      end

      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + ClrW'(1);
        if (clr_cnt_q == ClrW'(MaxDepth - 1)) begin
          clr_q <= 1'b0;
        end
      end

      if (accept) begin
        busy_q <= 1'b1;
      end else if (fire) begin
        busy_q <= 1'b0;
      end

      if (fire) begin
        out_valid_q <= 1'b1;
        ordinal_q   <= ordinal_q + 32'd1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rec_q <= rec_in;
      sid_q <= sid_in;
      kid_q <= kid_in;
    end
    if (fire) begin
      out_q <= report;
    end
  end

  `SSTM_ASSERT_NOW(a_no_accept_while_busy, busy_q, !s_axis_tready, "record taken while busy")
  `SSTM_ASSERT_NOW(a_no_update_in_clear, fire, !clr_q, "table update during clearing pass")
  `SSTM_ASSERT_NEXT(a_fire_loads_output, fire, out_valid_q && !busy_q, "report not loaded")
  `SSTM_ASSERT_NEXT(a_accept_then_busy, accept, busy_q && !s_axis_tready, "accept not tracked")
  `SSTM_ASSERT_NEXT(a_ordinal_steps, fire, ordinal_q == $past(ordinal_q) + 32'd1, "ordinal")

endmodule
